FILE: design/audio_cadence_estimator_defines.svh
// assertion macros shared by the cadence estimator rtl
`ifndef AUDIO_CADENCE_ESTIMATOR_DEFINES_SVH
`define AUDIO_CADENCE_ESTIMATOR_DEFINES_SVH

// condition holds at every clock edge outside reset
`define ACE_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ACE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define ACE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ace_pkg.sv
`timescale 1ns / 1ps

package ace_pkg;

    // field widths
    localparam int RATE_BITS = 24;
    localparam int SR_BITS   = 18;
    localparam int EST_BITS  = 16;
    localparam int PTS_BITS  = 64;

    // arithmetic widths
    localparam int A_BITS      = SR_BITS + RATE_BITS;
    localparam int LIMIT_LOG2  = 49;
    localparam int PROD_BITS   = (A_BITS > LIMIT_LOG2 + 1) ? A_BITS : LIMIT_LOG2 + 1;
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int MUL_STEPS   = LIMIT_LOG2 + 1;
    localparam int MUL_CNT_BITS = $clog2(MUL_STEPS + 1);
    localparam int NUM_BITS    = PROD_BITS + 2;
    localparam int DIV_STEPS   = EST_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
    localparam int HI_BITS     = NUM_BITS - EST_BITS;
    localparam int REM_BITS    = RATE_BITS + 1;

    // stream and configuration port widths
    localparam int IN_TDATA_BITS  = 168;
    localparam int OUT_TDATA_BITS = 72;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = SR_BITS;

    // register reset values
    localparam logic [SR_BITS-1:0]  SAMPLE_RATE_RST = SR_BITS'(48000);
    localparam logic [EST_BITS-1:0] MIN_SAMPLES_RST = EST_BITS'(160);
    localparam logic [EST_BITS-1:0] MAX_SAMPLES_RST = EST_BITS'(4000);
    localparam logic [EST_BITS-1:0] ESTIMATE_RST    = EST_BITS'(1920);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SAMPLE_RATE = 2'd0,
        CFG_MIN_SAMPLES = 2'd1,
        CFG_MAX_SAMPLES = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LAUNCH,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic [5:0]           pad;
        logic [RATE_BITS-1:0] tb_den;
        logic [RATE_BITS-1:0] tb_num;
        logic [PTS_BITS-1:0]  pts;
        logic                 pts_valid;
        logic                 interlaced;
        logic [RATE_BITS-1:0] rate_den;
        logic [RATE_BITS-1:0] rate_num;
    } in_item_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [4:0]           pad;
        logic                 cadence_interlaced;
        logic [RATE_BITS-1:0] cadence_rate_den;
        logic [RATE_BITS-1:0] cadence_rate_num;
        logic                 cadence_known;
        logic                 estimate_changed;
        logic [EST_BITS-1:0]  estimate_samples;
    } out_item_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } mul_stat_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

endpackage

FILE: design/ace_mul.sv
`timescale 1ns / 1ps

module ace_mul import ace_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [A_BITS-1:0]    mcand,
    input  logic [PTS_BITS-1:0]  mplier,
    output logic [PROD_BITS-1:0] prod,
    output mul_stat_t            stat
);

    localparam logic [ACC_BITS-1:0] PROD_LIMIT = ACC_BITS'(1) << LIMIT_LOG2;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    ovf_reg, ovf_next;
    logic [MUL_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [ACC_BITS-1:0]     acc_reg, acc_next;
    logic [A_BITS-1:0]       mcand_reg, mcand_next;
    logic [MUL_STEPS-1:0]    sh_reg, sh_next;
    logic [ACC_BITS-1:0]     addend;
    logic [ACC_BITS-1:0]     sum;

    // one multiplier bit per cycle, msb first, with sticky limit check
    always_comb begin
        addend     = sh_reg[MUL_STEPS-1] ? ACC_BITS'(mcand_reg) : '0;
        sum        = {acc_reg[ACC_BITS-2:0], 1'b0} + addend;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        sh_next    = sh_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = MUL_CNT_BITS'(MUL_STEPS);
            acc_next   = '0;
            mcand_next = mcand;
            sh_next    = mplier[MUL_STEPS-1:0];
            ovf_next   = (|mplier[PTS_BITS-1:MUL_STEPS]) && (|mcand);
        end else if (busy_reg) begin
            acc_next = sum;
            sh_next  = {sh_reg[MUL_STEPS-2:0], 1'b0};
            ovf_next = ovf_reg || (sum > PROD_LIMIT);
            cnt_next = cnt_reg - MUL_CNT_BITS'(1);
            if (cnt_reg == MUL_CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        sh_reg    <= sh_next;
    end

    assign prod      = acc_reg[PROD_BITS-1:0];
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

FILE: design/ace_div.sv
`timescale 1ns / 1ps

module ace_div import ace_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [PROD_BITS-1:0] num,
    input  logic [RATE_BITS-1:0] den,
    output logic [EST_BITS-1:0]  quot,
    output div_stat_t            stat
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    ovf_reg, ovf_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [REM_BITS-1:0]     rem_reg, rem_next;
    logic [REM_BITS-1:0]     d2_reg, d2_next;
    logic [EST_BITS-1:0]     sh_reg, sh_next;
    logic [NUM_BITS-1:0]     m;
    logic [HI_BITS-1:0]      hi;
    logic [REM_BITS-1:0]     d2;
    logic [REM_BITS:0]       t;
    logic [REM_BITS:0]       diff;
    logic                    ge;

    // half-up rounding as floor((2n + d) / 2d), one quotient bit per cycle;
    // quotients above the estimate width are flagged up front
    always_comb begin
        m         = {1'b0, num, 1'b0} + NUM_BITS'(den);
        hi        = m[NUM_BITS-1:EST_BITS];
        d2        = {den, 1'b0};
        t         = {rem_reg, sh_reg[EST_BITS-1]};
        diff      = t - {1'b0, d2_reg};
        ge        = t >= {1'b0, d2_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        d2_next   = d2_reg;
        sh_next   = sh_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIV_STEPS);
            ovf_next  = hi >= HI_BITS'(d2);
            rem_next  = hi[REM_BITS-1:0];
            d2_next   = d2;
            sh_next   = m[EST_BITS-1:0];
        end else if (busy_reg) begin
            rem_next = ge ? diff[REM_BITS-1:0] : t[REM_BITS-1:0];
            sh_next  = {sh_reg[EST_BITS-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        d2_reg  <= d2_next;
        sh_reg  <= sh_next;
    end

    assign quot      = sh_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

FILE: design/audio_cadence_estimator.sv
`timescale 1ns / 1ps
`include "audio_cadence_estimator_defines.svh"
// Audio cadence estimator: one frame descriptor in, one result out.
// s_ channel carries a frame descriptor per transaction, m_ channel returns
// the samples-per-frame estimate and the remembered nominal rate after it.
// The cfg channel writes sample_rate, min_samples and max_samples at any
// time (cfg_ready is always high); write it only while the block is idle.
// One descriptor is processed at a time. States from acceptance to the result:
//   setup, launch, done when neither the multiplier nor the divider is needed,
//   setup, launch, divide, done on the nominal-rate path (16-step serial divider),
//   setup, launch, multiply, done when the timestamp product exceeds the limit,
//   setup, launch, multiply, divide, done on the timestamp path (50-step serial
//   multiplier over the timestamp delta, then the divider).
// A new descriptor is taken only once the block is back in the idle state.
// The result sits in an output register; the next descriptor is accepted
// while it waits, and a stalled receiver only holds the finished item in
// the final state until the register frees up.
// Synchronous reset restores register defaults, an estimate of 1920,
// no remembered rate and no previous timestamp.
module audio_cadence_estimator import ace_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // frame descriptor input
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // rate_num, rate_den, interlaced, pts_valid, pts, tb_num, tb_den, zero pad
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    // estimate result output
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // estimate_samples, estimate_changed, cadence_known, cadence_rate_num,
    // cadence_rate_den, cadence_interlaced, zero pad
    output logic [OUT_TDATA_BITS-1:0] m_tdata
);

    state_t               state_reg, state_next;
    in_item_t             item_reg;
    out_item_t            out_reg, out_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 out_load;

    logic [SR_BITS-1:0]   sr_reg;
    logic [EST_BITS-1:0]  min_reg;
    logic [EST_BITS-1:0]  max_reg;

    logic [EST_BITS-1:0]  estimate_reg, estimate_next;
    logic                 changed_reg, changed_next;
    logic [PTS_BITS-1:0]  prev_pts_reg, prev_pts_next;
    logic                 prev_valid_reg, prev_valid_next;
    logic [RATE_BITS-1:0] prev_tb_num_reg, prev_tb_num_next;
    logic [RATE_BITS-1:0] prev_tb_den_reg, prev_tb_den_next;
    logic [RATE_BITS-1:0] known_num_reg, known_num_next;
    logic [RATE_BITS-1:0] known_den_reg, known_den_next;
    logic                 known_intl_reg, known_intl_next;
    logic                 path_a_reg, path_a_next;
    logic                 offer_b_reg, offer_b_next;

    logic [A_BITS-1:0]    a_reg, a_next;
    logic [PTS_BITS-1:0]  delta_reg, delta_next;

    logic                 path_a;
    logic                 pts_ok;
    logic                 known_old;
    logic                 known_now;
    logic                 offer_b;

    logic                 mul_start;
    logic [PROD_BITS-1:0] mul_prod;
    mul_stat_t            mul_stat;
    logic                 div_start;
    logic [PROD_BITS-1:0] div_num;
    logic [RATE_BITS-1:0] div_den;
    logic [EST_BITS-1:0]  div_quot;
    div_stat_t            div_stat;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sr_reg  <= SAMPLE_RATE_RST;
            min_reg <= MIN_SAMPLES_RST;
            max_reg <= MAX_SAMPLES_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_RATE: sr_reg  <= cfg_data;
                CFG_MIN_SAMPLES: min_reg <= cfg_data[EST_BITS-1:0];
                CFG_MAX_SAMPLES: max_reg <= cfg_data[EST_BITS-1:0];
                default: ;
            endcase
        end
    end

    // descriptor capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= in_item_t'(s_tdata);
        end
    end

    // path decisions from the captured descriptor and the current history
    always_comb begin
        path_a    = (item_reg.rate_num != '0) && (item_reg.rate_den != '0);
        pts_ok    = item_reg.pts_valid && (item_reg.tb_num != '0) && (item_reg.tb_den != '0);
        known_old = (known_num_reg != '0) && (known_den_reg != '0);
        known_now = (known_num_reg != '0) && (known_den_reg != '0);
        offer_b   = pts_ok && !(path_a || known_old) && prev_valid_reg
                    && (prev_tb_num_reg == item_reg.tb_num)
                    && (prev_tb_den_reg == item_reg.tb_den)
                    && ($signed(item_reg.pts) > $signed(prev_pts_reg));
        a_next    = A_BITS'(sr_reg)
                    * A_BITS'(path_a ? item_reg.rate_den : item_reg.tb_num);
        delta_next = item_reg.pts - prev_pts_reg;
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        estimate_next    = estimate_reg;
        changed_next     = changed_reg;
        prev_pts_next    = prev_pts_reg;
        prev_valid_next  = prev_valid_reg;
        prev_tb_num_next = prev_tb_num_reg;
        prev_tb_den_next = prev_tb_den_reg;
        known_num_next   = known_num_reg;
        known_den_next   = known_den_reg;
        known_intl_next  = known_intl_reg;
        path_a_next      = path_a_reg;
        offer_b_next     = offer_b_reg;
        mul_start        = 1'b0;
        div_start        = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                path_a_next  = path_a;
                offer_b_next = offer_b;
                changed_next = 1'b0;
                if (path_a) begin
                    known_num_next  = item_reg.rate_num;
                    known_den_next  = item_reg.rate_den;
                    known_intl_next = item_reg.interlaced;
                end
                if (pts_ok) begin
                    prev_pts_next    = item_reg.pts;
                    prev_valid_next  = 1'b1;
                    prev_tb_num_next = item_reg.tb_num;
                    prev_tb_den_next = item_reg.tb_den;
                end
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                if (path_a_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else if (offer_b_reg) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    if (mul_stat.ovf) begin
                        state_next = ST_DONE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (!div_stat.ovf && (div_quot >= min_reg) && (div_quot <= max_reg)) begin
                        estimate_next = div_quot;
                        changed_next  = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register and valid
    always_comb begin
        out_next                    = out_reg;
        out_next.pad                = '0;
        out_next.estimate_samples   = estimate_reg;
        out_next.estimate_changed   = changed_reg;
        out_next.cadence_known      = known_now;
        out_next.cadence_rate_num   = known_num_reg;
        out_next.cadence_rate_den   = known_den_reg;
        out_next.cadence_interlaced = known_intl_reg;
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // control and history state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            estimate_reg    <= ESTIMATE_RST;
            changed_reg     <= 1'b0;
            prev_pts_reg    <= '0;
            prev_valid_reg  <= 1'b0;
            prev_tb_num_reg <= RATE_BITS'(1);
            prev_tb_den_reg <= '0;
            known_num_reg   <= '0;
            known_den_reg   <= RATE_BITS'(1);
            known_intl_reg  <= 1'b0;
            path_a_reg      <= 1'b0;
            offer_b_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            estimate_reg    <= estimate_next;
            changed_reg     <= changed_next;
            prev_pts_reg    <= prev_pts_next;
            prev_valid_reg  <= prev_valid_next;
            prev_tb_num_reg <= prev_tb_num_next;
            prev_tb_den_reg <= prev_tb_den_next;
            known_num_reg   <= known_num_next;
            known_den_reg   <= known_den_next;
            known_intl_reg  <= known_intl_next;
            path_a_reg      <= path_a_next;
            offer_b_reg     <= offer_b_next;
        end
    end

    // operand and result payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SETUP) begin
            a_reg     <= a_next;
            delta_reg <= delta_next;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // divider operands: nominal rate path starts from launch, timestamp path from the multiplier
    assign div_num = (state_reg == ST_LAUNCH) ? PROD_BITS'(a_reg) : mul_prod;
    assign div_den = (state_reg == ST_LAUNCH) ? item_reg.rate_num : item_reg.tb_den;

    ace_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (a_reg),
        .mplier  (delta_reg),
        .prod    (mul_prod),
        .stat    (mul_stat)
    );

    ace_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    // checks
    `ACE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `ACE_ASSERT_NOW(a_one_unit_start, !(mul_start && div_start), "multiplier and divider both started")
    `ACE_ASSERT_SAME(a_out_free, out_load, !m_tvalid_reg || m_tready, "result overwritten")

endmodule

FILE: bench/cadence_checker.sv
`timescale 1ns / 1ps

module cadence_checker import ace_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    // rate_num, rate_den, interlaced, pts_valid, pts, tb_num, tb_den, zero pad
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // estimate_samples, estimate_changed, cadence_known, cadence_rate_num,
    // cadence_rate_den, cadence_interlaced, zero pad
    input  logic [OUT_TDATA_BITS-1:0] m_tdata,
    output int                        failures,
    output int                        outstanding
);

    // products above this bound give candidates far beyond the estimate range
    localparam logic [63:0] CANDIDATE_LIMIT = 64'd1 << LIMIT_LOG2;

    // register copies
    logic [SR_BITS-1:0]   rate_hz;
    logic [EST_BITS-1:0]  floor_samples;
    logic [EST_BITS-1:0]  ceil_samples;

    // tracked block state
    logic [EST_BITS-1:0]  est;
    logic [PTS_BITS-1:0]  last_pts;
    logic                 last_pts_ok;
    logic [RATE_BITS-1:0] last_tb_num;
    logic [RATE_BITS-1:0] last_tb_den;
    logic [RATE_BITS-1:0] nominal_num;
    logic [RATE_BITS-1:0] nominal_den;
    logic                 nominal_intl;

    out_item_t predicted_results[$];
    int        mismatch_count;

    // exact rational division, half rounds up
    function automatic logic [63:0] round_half_up(input logic [63:0] n, input logic [63:0] d);
        return (64'd2 * n + d) / (64'd2 * d);
    endfunction

    // store a candidate only inside the accepted window
    function automatic logic take_candidate(input logic [63:0] cand);
        if (cand >= 64'(floor_samples) && cand <= 64'(ceil_samples)) begin
            est = cand[EST_BITS-1:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one frame descriptor and build the result it produces
    function automatic out_item_t advance_cadence(input in_item_t f);
        logic        changed;
        logic        known;
        logic [63:0] delta;
        logic [63:0] gain;
        out_item_t   r;
        changed = 1'b0;
        // nominal rate is remembered before the timestamp path is considered
        if (f.rate_num != '0 && f.rate_den != '0) begin
            changed = changed | take_candidate(
                round_half_up(64'(rate_hz) * 64'(f.rate_den), 64'(f.rate_num)));
            nominal_num  = f.rate_num;
            nominal_den  = f.rate_den;
            nominal_intl = f.interlaced;
        end
        known = nominal_num != '0 && nominal_den != '0;
        // timestamp path only while no nominal rate was ever seen
        if (f.pts_valid && f.tb_num != '0 && f.tb_den != '0) begin
            if (!known && last_pts_ok && last_tb_num == f.tb_num && last_tb_den == f.tb_den
                && $signed(f.pts) > $signed(last_pts)) begin
                delta = f.pts - last_pts;
                gain  = 64'(rate_hz) * 64'(f.tb_num);
                if (gain == '0)
                    changed = changed | take_candidate('0);
                else if (delta <= CANDIDATE_LIMIT / gain)
                    changed = changed | take_candidate(
                        round_half_up(gain * delta, 64'(f.tb_den)));
            end
            last_pts    = f.pts;
            last_pts_ok = 1'b1;
            last_tb_num = f.tb_num;
            last_tb_den = f.tb_den;
        end
        r = '0;
        r.estimate_samples   = est;
        r.estimate_changed   = changed;
        r.cadence_known      = known;
        r.cadence_rate_num   = nominal_num;
        r.cadence_rate_den   = nominal_den;
        r.cadence_interlaced = nominal_intl;
        return r;
    endfunction

    function automatic int field_check(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : monitor
        out_item_t got;
        out_item_t want;
        if (!aresetn) begin
            rate_hz       = SAMPLE_RATE_RST;
            floor_samples = MIN_SAMPLES_RST;
            ceil_samples  = MAX_SAMPLES_RST;
            est           = ESTIMATE_RST;
            last_pts      = '0;
            last_pts_ok   = 1'b0;
            last_tb_num   = RATE_BITS'(1);
            last_tb_den   = '0;
            nominal_num   = '0;
            nominal_den   = RATE_BITS'(1);
            nominal_intl  = 1'b0;
            predicted_results.delete();
            mismatch_count = 0;
        end else begin
            // register write transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SAMPLE_RATE: rate_hz = cfg_data;
                    CFG_MIN_SAMPLES: floor_samples = cfg_data[EST_BITS-1:0];
                    CFG_MAX_SAMPLES: ceil_samples = cfg_data[EST_BITS-1:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (predicted_results.size() == 0) begin
                    $error("result with nothing pending: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = predicted_results[0];
                    predicted_results.delete(0);
                    mismatch_count += field_check("estimate_samples",
                        want.estimate_samples, got.estimate_samples);
                    mismatch_count += field_check("estimate_changed",
                        want.estimate_changed, got.estimate_changed);
                    mismatch_count += field_check("cadence_known",
                        want.cadence_known, got.cadence_known);
                    mismatch_count += field_check("cadence_rate_num",
                        want.cadence_rate_num, got.cadence_rate_num);
                    mismatch_count += field_check("cadence_rate_den",
                        want.cadence_rate_den, got.cadence_rate_den);
                    mismatch_count += field_check("cadence_interlaced",
                        want.cadence_interlaced, got.cadence_interlaced);
                end
            end
            // descriptor transaction
            if (s_tvalid && s_tready)
                predicted_results.insert(predicted_results.size(),
                                         advance_cadence(in_item_t'(s_tdata)));
        end
        failures    <= mismatch_count;
        outstanding <= predicted_results.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ace_pkg::*;

    localparam logic [RATE_BITS-1:0] RATE_ALL = '1;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = CFG_SAMPLE_RATE;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    int                        failures;
    int                        outstanding;

    // pacing and timestamp sequence state
    logic                      quiet    = 1'b0;
    logic [SR_BITS-1:0]        cur_rate = SAMPLE_RATE_RST;
    logic [PTS_BITS-1:0]       seq_pts  = '0;
    logic [RATE_BITS-1:0]      seq_num  = RATE_BITS'(1);
    logic [RATE_BITS-1:0]      seq_den  = RATE_BITS'(90000);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    audio_cadence_estimator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    cadence_checker watch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    function automatic in_item_t make_frame(
        input logic [RATE_BITS-1:0] rnum, rden,
        input logic                 intl, pv,
        input logic [PTS_BITS-1:0]  stamp,
        input logic [RATE_BITS-1:0] tnum, tden);
        in_item_t f;
        f.pad        = '0;
        f.rate_num   = rnum;
        f.rate_den   = rden;
        f.interlaced = intl;
        f.pts_valid  = pv;
        f.pts        = stamp;
        f.tb_num     = tnum;
        f.tb_den     = tden;
        return f;
    endfunction

    // mostly advancing timestamps on a steady time base, rest broken on purpose
    function automatic in_item_t timestamp_frame();
        int unsigned          pick;
        logic [63:0]          step;
        logic [RATE_BITS-1:0] rn, rd, w1, w2;
        logic                 sel, intl;
        in_item_t             f;
        pick = $urandom_range(0, 99);
        sel  = 1'($urandom);
        intl = 1'($urandom);
        w1   = RATE_BITS'($urandom);
        w2   = RATE_BITS'($urandom);
        // a rate with one half missing never counts as known
        rn = sel ? w1 : '0;
        rd = sel ? '0 : w2;
        if (pick < 4) begin
            seq_num = RATE_BITS'($urandom_range(1, 4));
            seq_den = RATE_BITS'($urandom_range(1000, 200000));
            seq_pts = {$urandom, $urandom};
        end
        if (cur_rate == '0)
            step = 64'($urandom_range(1, 5000));
        else
            step = (64'($urandom_range(50, 6000)) * seq_den) / (64'(cur_rate) * seq_num)
                   + 64'($urandom_range(0, 3));
        sel = 1'($urandom);
        if (pick < 70) begin
            seq_pts = seq_pts + step;
            f = make_frame(rn, rd, intl, 1'b1, seq_pts, seq_num, seq_den);
        end else if (pick < 77) begin
            // timestamp absent
            f = make_frame(rn, rd, intl, 1'b0, {$urandom, $urandom}, w1, w2);
        end else if (pick < 83) begin
            // time base with a zero half
            f = make_frame(rn, rd, intl, 1'b1, {$urandom, $urandom},
                           sel ? '0 : w1, sel ? w2 : '0);
        end else if (pick < 88) begin
            // standing still or stepping back
            seq_pts = seq_pts - 64'($urandom_range(0, 2)) * step;
            f = make_frame(rn, rd, intl, 1'b1, seq_pts, seq_num, seq_den);
        end else if (pick < 92) begin
            // jump large enough to overflow the candidate
            seq_pts = seq_pts + ({$urandom, $urandom} >> $urandom_range(0, 40));
            f = make_frame(rn, rd, intl, 1'b1, seq_pts, seq_num, seq_den);
        end else if (pick < 96) begin
            f = make_frame(rn, rd, intl, 1'b1, {$urandom, $urandom}, w1, w2);
        end else begin
            seq_pts = {$urandom, $urandom};
            f = make_frame(rn, rd, intl, 1'b1, seq_pts, seq_num, seq_den);
        end
        return f;
    endfunction

    // nominal rates aimed near the accepted window, plus full-range noise
    function automatic in_item_t rate_frame();
        int unsigned          pick;
        logic [63:0]          num;
        logic [RATE_BITS-1:0] den, w1, w2, t1, t2;
        logic                 sel, intl, pv;
        in_item_t             f;
        pick = $urandom_range(0, 99);
        w1   = RATE_BITS'($urandom);
        w2   = RATE_BITS'($urandom);
        t1   = RATE_BITS'($urandom);
        t2   = RATE_BITS'($urandom);
        sel  = 1'($urandom);
        intl = 1'($urandom);
        pv   = 1'($urandom);
        den  = RATE_BITS'($urandom_range(1, 2000));
        num  = 64'(cur_rate) * den / $urandom_range(50, 6000);
        if (num == '0 || num > 64'(RATE_ALL))
            num = 64'(w1 | RATE_BITS'(1));
        if (pick < 60)
            f = make_frame(num[RATE_BITS-1:0], den, intl, pv, {$urandom, $urandom}, t1, t2);
        else if (pick < 75)
            f = make_frame(w1, w2, intl, pv, {$urandom, $urandom}, t1, t2);
        else if (pick < 85)
            f = make_frame(sel ? '0 : w1, sel ? w2 : '0, intl, pv, {$urandom, $urandom},
                           t1, t2);
        else
            f = make_frame('0, '0, intl, pv, {$urandom, $urandom}, t1, t2);
        return f;
    endfunction

    task automatic send_frame(input in_item_t f);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold off until every predicted result has been returned
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [SR_BITS-1:0] hz,
                                  input logic [EST_BITS-1:0] lo, hi);
        logic [CFG_DATA_BITS-1:0] value [CFG_SAMPLE_RATE:CFG_MAX_SAMPLES];
        logic [CFG_DATA_BITS-1:0] noise;
        noise = CFG_DATA_BITS'($urandom);
        value[CFG_SAMPLE_RATE] = hz;
        // bits above the 16-bit window registers are dropped by the block
        value[CFG_MIN_SAMPLES] = {noise[CFG_DATA_BITS-1:EST_BITS], lo};
        noise = CFG_DATA_BITS'($urandom);
        value[CFG_MAX_SAMPLES] = {noise[CFG_DATA_BITS-1:EST_BITS], hi};
        for (int i = CFG_SAMPLE_RATE; i <= CFG_MAX_SAMPLES; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= value[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        cur_rate = hz;
    endtask

    // result receiver with random back-pressure
    initial begin : result_sink
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // timestamp path at reset settings, no nominal rate yet
        send_frame(make_frame('0, '0, 1'b0, 1'b0, '0, '0, '0));
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd1000, 24'd1, 24'd48000));
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd2920, 24'd1, 24'd48000));
        // standing still, then stepping back
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd2920, 24'd1, 24'd48000));
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd2000, 24'd1, 24'd48000));
        // absent timestamp keeps the previous one
        send_frame(make_frame('0, '0, 1'b0, 1'b0, 64'd999999, 24'd1, 24'd48000));
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd3601, 24'd1, 24'd48000));
        // time base change, then an exact half
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd3601, 24'd1, 24'd96000));
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd6802, 24'd1, 24'd96000));
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd6802, 24'd1, 24'd90000));
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd9805, 24'd1, 24'd90000));
        // invalid time base halves
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd20000, 24'd0, 24'd90000));
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd20000, 24'd1, 24'd0));
        // overflowing advance, then the most negative timestamp
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 24'd1, 24'd90000));
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'h8000_0000_0000_0000, 24'd1, 24'd90000));
        // above the window, below the window
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'h8000_0000_0000_249F, 24'd1, 24'd90000));
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'h8000_0000_0000_2535, 24'd1, 24'd90000));
        // half-given rates do not count as known
        send_frame(make_frame(24'd30, '0, 1'b0, 1'b1, 64'h8000_0000_0000_30F0,
                              24'd1, 24'd90000));
        send_frame(make_frame('0, 24'd1001, 1'b1, 1'b1, 64'h8000_0000_0000_37F8,
                              24'd1, 24'd90000));

        // random timestamp phases over several settings
        seq_pts = {$urandom, $urandom};
        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: write_settings(18'd48000, 16'd0, 16'hFFFF);
                1: write_settings(18'd0, 16'd0, 16'd100);
                2: write_settings(18'h3FFFF, 16'd160, 16'd4000);
                3: write_settings(18'd1, 16'd0, 16'hFFFF);
                default: write_settings(SR_BITS'($urandom_range(1, 192000)),
                                        EST_BITS'($urandom), EST_BITS'($urandom));
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 49) == 0)
                    drain();
                send_frame(timestamp_frame());
            end
        end

        // nominal rate path, once known it stays known
        drain();
        write_settings(18'd48000, 16'd160, 16'd4000);
        quiet = 1'b0;
        send_frame(make_frame(24'd30000, 24'd1001, 1'b1, 1'b1, 64'd5, 24'd1, 24'd48000));
        send_frame(make_frame(24'd25, 24'd1, 1'b0, 1'b0, '0, '0, '0));
        send_frame(make_frame(RATE_ALL, 24'd1, 1'b0, 1'b0, '0, '0, '0));
        send_frame(make_frame(24'd1, RATE_ALL, 1'b1, 1'b0, '0, '0, '0));
        send_frame(make_frame('0, 24'd5, 1'b1, 1'b0, '0, '0, '0));
        // timestamp path is skipped once a rate is known
        send_frame(make_frame('0, '0, 1'b0, 1'b1, 64'd1925, 24'd1, 24'd48000));
        send_frame(make_frame(24'd24000, 24'd1001, 1'b0, 1'b0, '0, '0, '0));
        send_frame(make_frame(24'd60000, 24'd1001, 1'b1, 1'b0, '0, '0, '0));

        for (int p = 0; p < 3; p++) begin
            drain();
            case (p)
                0: write_settings(18'd192000, 16'd0, 16'hFFFF);
                1: write_settings(SR_BITS'($urandom_range(1, 192000)),
                                  EST_BITS'($urandom), EST_BITS'($urandom));
                // empty window, nothing can be accepted
                default: write_settings(18'd44100, 16'hFFFF, 16'd0);
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 70; n++) begin
                if ($urandom_range(0, 49) == 0)
                    drain();
                send_frame(rate_frame());
            end
        end

        drain();
        repeat (100) @(posedge aclk);
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
